// File: rtl/vpcc_pkg.sv
// Shared types, constants and a helper function of the voxel pack container checker.
package vpcc_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam logic [31:0] MAX_SCALE_COUNT = 32'd64;

    localparam logic [31:0] TAG_WORD0 = 32'h5054_4256;
    localparam logic [31:0] TAG_WORD1 = 32'h344B_4341;
    localparam logic [31:0] FORMAT_VERSION = 32'd4;
    localparam logic [31:0] LEAF_EDGE = 32'd8;
    localparam logic [31:0] COARSE_RES_MAX = 32'd8;
    localparam logic [31:0] PROFILE_MAX = 32'd2;
    localparam logic [3:0] HDR_WORDS = 4'd13;
    localparam logic [33:0] WORDS_MAX = 34'h3_FFFF_FFFF;

    localparam logic [3:0] ST_OK = 4'd0;
    localparam logic [3:0] ST_SHORT_HEADER = 4'd1;
    localparam logic [3:0] ST_BAD_TAG = 4'd2;
    localparam logic [3:0] ST_BAD_VERSION = 4'd3;
    localparam logic [3:0] ST_ZERO_DIM = 4'd4;
    localparam logic [3:0] ST_BAD_LEAF_SIZE = 4'd5;
    localparam logic [3:0] ST_BAD_COARSE = 4'd6;
    localparam logic [3:0] ST_BAD_PROFILE = 4'd7;
    localparam logic [3:0] ST_BAD_KEEP = 4'd8;
    localparam logic [3:0] ST_LEAF_OVERFLOW = 4'd9;
    localparam logic [3:0] ST_LEAF_MISMATCH = 4'd10;
    localparam logic [3:0] ST_TRUNCATED = 4'd11;
    localparam logic [3:0] ST_PAYLOAD_SHORT = 4'd14;
    localparam logic [3:0] ST_TRAILING = 4'd15;

    localparam logic [1:0] OFS_NONE = 2'd0;
    localparam logic [1:0] OFS_FIRST_NONZERO = 2'd1;
    localparam logic [1:0] OFS_NOT_RISING = 2'd2;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [3:0]  status;
        logic [33:0] words_seen;
    } t_out;

    // Beat as handed from the front to the back.
    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic [3:0]  hdr_idx;
        logic [33:0] words;
    } t_beat;

    function automatic logic [29:0] leaves_along(input logic [31:0] dim);
        logic [32:0] s;
        s = {1'b0, dim} + 33'd7;
        return s[32:3];
    endfunction

endpackage

// File: rtl/vpcc_front.sv
// Front end: accepts words, counts them and tags the header position.
module vpcc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  vpcc_pkg::t_in   i_data,
    output logic            o_push,
    input  logic            i_full,
    output vpcc_pkg::t_beat o_beat
);
    logic [3:0]  r_hdr_idx, n_hdr_idx;
    logic [33:0] r_words;
    logic [33:0] w_words;

    assign o_ready = !i_full;
    assign o_push = i_valid && !i_full;
    assign w_words = (r_words < vpcc_pkg::WORDS_MAX) ? r_words + 34'd1 : r_words;

    always_comb begin
        o_beat.word = i_data.word;
        o_beat.last = i_data.last;
        o_beat.hdr_idx = r_hdr_idx;
        o_beat.words = w_words;
        n_hdr_idx = (r_hdr_idx < vpcc_pkg::HDR_WORDS) ? r_hdr_idx + 4'd1 : r_hdr_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx <= '0;
            r_words <= '0;
        end else if (o_push) begin
            if (i_data.last) begin
                r_hdr_idx <= '0;
                r_words <= '0;
            end else begin
                r_hdr_idx <= n_hdr_idx;
                r_words <= w_words;
            end
        end
    end
endmodule

// File: rtl/vpcc_queue.sv
// Short register queue between the front and the back.
module vpcc_queue #(
    parameter int DEPTH = vpcc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vpcc_pkg::t_beat i_beat,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output vpcc_pkg::t_beat o_beat
);
    localparam int PW = $clog2(DEPTH);

    vpcc_pkg::t_beat r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;
    logic          w_pop;

    assign o_full = (r_cnt == (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_beat = r_mem[r_rd];
    assign w_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end
endmodule

// File: rtl/vpcc_back.sv
// Back end: walks the file sections, runs the checks and registers the verdict.
module vpcc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_pop,
    input  vpcc_pkg::t_beat i_beat,
    output logic            o_valid,
    input  logic            i_ready,
    output vpcc_pkg::t_out  o_data
);
    localparam logic [2:0] SEC_HEADER = 3'd0;
    localparam logic [2:0] SEC_SCALES = 3'd1;
    localparam logic [2:0] SEC_OFFSETS = 3'd2;
    localparam logic [2:0] SEC_PAYLOAD = 3'd3;
    localparam logic [2:0] SEC_DONE = 3'd4;
    localparam logic [2:0] SEC_EXTRA = 3'd5;
    localparam logic [2:0] SEC_SKIP = 3'd6;

    logic [31:0] r_hdr [13];
    logic [2:0]  r_section, n_section;
    logic [32:0] r_sidx, n_sidx;
    logic [31:0] r_prev, n_prev;
    logic [1:0]  r_ofs, n_ofs;
    logic [3:0]  r_fault, n_fault;
    logic [31:0] r_rem, n_rem;
    logic [59:0] r_xy;
    logic [31:0] r_prod;
    logic        r_ovf;
    logic        r_out_valid;
    vpcc_pkg::t_out r_out;

    logic        w_take;
    logic [31:0] w;
    logic [32:0] w_sidx_inc;
    logic [61:0] w_prod;
    logic [3:0]  w_judge;
    logic [3:0]  w_verdict;

    assign o_pop = !r_out_valid || i_ready;
    assign w_take = i_valid && o_pop;
    assign w = i_beat.word;
    assign w_sidx_inc = r_sidx + 33'd1;
    assign w_prod = {30'd0, r_xy[31:0]} * {32'd0, vpcc_pkg::leaves_along(w)};
    assign o_valid = r_out_valid;
    assign o_data = r_out;

    // Header checks, first failing check wins; word 12 (scale count) is the current beat.
    always_comb begin
        if (r_hdr[0] != vpcc_pkg::TAG_WORD0 || r_hdr[1] != vpcc_pkg::TAG_WORD1) begin
            w_judge = vpcc_pkg::ST_BAD_TAG;
        end else if (r_hdr[2] != vpcc_pkg::FORMAT_VERSION) begin
            w_judge = vpcc_pkg::ST_BAD_VERSION;
        end else if (r_hdr[3] == '0 || r_hdr[4] == '0 || r_hdr[5] == '0
                     || r_hdr[6] == '0) begin
            w_judge = vpcc_pkg::ST_ZERO_DIM;
        end else if (r_hdr[7] != vpcc_pkg::LEAF_EDGE) begin
            w_judge = vpcc_pkg::ST_BAD_LEAF_SIZE;
        end else if (r_hdr[8] == '0 || r_hdr[8] > vpcc_pkg::COARSE_RES_MAX) begin
            w_judge = vpcc_pkg::ST_BAD_COARSE;
        end else if (r_hdr[11] > vpcc_pkg::PROFILE_MAX) begin
            w_judge = vpcc_pkg::ST_BAD_PROFILE;
        end else if (r_hdr[9] > r_hdr[6] || w > vpcc_pkg::MAX_SCALE_COUNT
                     || w > r_hdr[9]) begin
            w_judge = vpcc_pkg::ST_BAD_KEEP;
        end else if (r_ovf) begin
            w_judge = vpcc_pkg::ST_LEAF_OVERFLOW;
        end else if (r_hdr[10] != r_prod) begin
            w_judge = vpcc_pkg::ST_LEAF_MISMATCH;
        end else begin
            w_judge = vpcc_pkg::ST_OK;
        end
    end

    always_comb begin
        n_section = r_section;
        n_sidx = r_sidx;
        n_prev = r_prev;
        n_ofs = r_ofs;
        n_fault = r_fault;
        n_rem = r_rem;
        case (r_section)
            SEC_HEADER: begin
                if (i_beat.hdr_idx == vpcc_pkg::HDR_WORDS - 4'd1) begin
                    n_fault = w_judge;
                    n_sidx = '0;
                    if (w_judge != vpcc_pkg::ST_OK) begin
                        n_section = SEC_SKIP;
                    end else if (w != '0) begin
                        n_section = SEC_SCALES;
                    end else begin
                        n_section = SEC_OFFSETS;
                    end
                end
            end
            SEC_SCALES: begin
                n_sidx = w_sidx_inc;
                if (w_sidx_inc >= {1'b0, r_hdr[12]}) begin
                    n_section = SEC_OFFSETS;
                    n_sidx = '0;
                end
            end
            SEC_OFFSETS: begin
                if (r_sidx == '0) begin
                    if (w != '0 && r_ofs == vpcc_pkg::OFS_NONE) begin
                        n_ofs = vpcc_pkg::OFS_FIRST_NONZERO;
                    end
                end else if (r_prev >= w && r_ofs == vpcc_pkg::OFS_NONE) begin
                    n_ofs = vpcc_pkg::OFS_NOT_RISING;
                end
                n_prev = w;
                n_sidx = w_sidx_inc;
                if (w_sidx_inc >= {1'b0, r_hdr[10]} + 33'd1) begin
                    n_rem = w;
                    n_sidx = '0;
                    n_section = (w != '0) ? SEC_PAYLOAD : SEC_DONE;
                end
            end
            SEC_PAYLOAD: begin
                n_rem = r_rem - 32'd1;
                if (r_rem == 32'd1) begin
                    n_section = SEC_DONE;
                end
            end
            SEC_DONE: begin
                n_section = SEC_EXTRA;
            end
            default: begin
                n_section = r_section;
            end
        endcase

        if (n_section == SEC_HEADER) begin
            w_verdict = vpcc_pkg::ST_SHORT_HEADER;
        end else if (n_fault != vpcc_pkg::ST_OK) begin
            w_verdict = n_fault;
        end else if (n_section == SEC_SCALES || n_section == SEC_OFFSETS) begin
            w_verdict = vpcc_pkg::ST_TRUNCATED;
        end else if (n_ofs != vpcc_pkg::OFS_NONE) begin
            w_verdict = vpcc_pkg::ST_TRUNCATED + {2'd0, n_ofs};
        end else if (n_section == SEC_PAYLOAD) begin
            w_verdict = vpcc_pkg::ST_PAYLOAD_SHORT;
        end else if (n_section == SEC_EXTRA) begin
            w_verdict = vpcc_pkg::ST_TRAILING;
        end else begin
            w_verdict = vpcc_pkg::ST_OK;
        end
    end

    // Header capture and the leaf-count product, built up as the dimensions arrive.
    always_ff @(posedge i_clk) begin
        if (w_take && r_section == SEC_HEADER && i_beat.hdr_idx < vpcc_pkg::HDR_WORDS) begin
            r_hdr[i_beat.hdr_idx] <= w;
            if (i_beat.hdr_idx == 4'd4) begin
                r_xy <= {30'd0, vpcc_pkg::leaves_along(r_hdr[3])}
                        * {30'd0, vpcc_pkg::leaves_along(w)};
            end
            if (i_beat.hdr_idx == 4'd5) begin
                r_ovf <= (r_xy[59:32] != '0) || (w_prod[61:32] != '0);
                r_prod <= w_prod[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_beat.last) begin
            r_out.status <= w_verdict;
            r_out.words_seen <= i_beat.words;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section <= SEC_HEADER;
            r_sidx <= '0;
            r_prev <= '0;
            r_ofs <= vpcc_pkg::OFS_NONE;
            r_fault <= vpcc_pkg::ST_OK;
            r_rem <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take && i_beat.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_take) begin
                if (i_beat.last) begin
                    r_section <= SEC_HEADER;
                    r_sidx <= '0;
                    r_prev <= '0;
                    r_ofs <= vpcc_pkg::OFS_NONE;
                    r_fault <= vpcc_pkg::ST_OK;
                    r_rem <= '0;
                end else begin
                    r_section <= n_section;
                    r_sidx <= n_sidx;
                    r_prev <= n_prev;
                    r_ofs <= n_ofs;
                    r_fault <= n_fault;
                    r_rem <= n_rem;
                end
            end
        end
    end

    a_header_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_section == SEC_HEADER |-> r_fault == vpcc_pkg::ST_OK && r_ofs == vpcc_pkg::OFS_NONE)
        else $error("fault recorded while still in the header");
    a_skip_has_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_section == SEC_SKIP |-> r_fault != vpcc_pkg::ST_OK)
        else $error("skipping words without a header fault");
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_section == SEC_PAYLOAD |-> r_rem != '0)
        else $error("payload section with nothing left to count");
    a_verdict_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid && !(w_take && i_beat.last) |=> !r_out_valid)
        else $error("verdict raised without a last beat");
endmodule

// File: rtl/voxel_pack_container_checker.sv
// Top level of the voxel pack container checker.
// Takes one 32-bit word per cycle while o_ready is high, and returns one status and
// word count on the word flagged last. A beat moves through the front (word count,
// header position), a short register queue and the back (section walk and checks).
// The last word is pushed into the queue when it is accepted, and the back registers
// the verdict when it takes that beat from the queue. The back retires one beat per
// cycle, so a stream runs at one word per cycle unless the verdict register is left
// waiting, and the queue then absorbs up to QUEUE_DEPTH further beats.
// QUEUE_DEPTH must be a power of two, at least two.
module voxel_pack_container_checker #(
    parameter int QUEUE_DEPTH = vpcc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  vpcc_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output vpcc_pkg::t_out o_data
);
    logic            w_push, w_full, w_q_valid, w_pop;
    vpcc_pkg::t_beat w_in_beat, w_q_beat;

    vpcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_beat  (w_in_beat)
    );

    vpcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_beat  (w_in_beat),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_beat  (w_q_beat)
    );

    vpcc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_pop   (w_pop),
        .i_beat  (w_q_beat),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );
endmodule
